FILE: src/sbs_pkg.sv
// sbs_pkg: shared types and constants for the serial 1-bit slave shifter
// depends on nothing; used by the output buffer and the top level
package sbs_pkg;

  localparam int unsigned TX_DEPTH_DEF = 64;
  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned CNT_W        = 16;
  localparam int unsigned CFG_IDX_W    = 1;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_APPEND = 2'd1,
    OP_CLEAR  = 2'd2
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DRIVE_MODE = 1'b0,
    CFG_RX_MAX     = 1'b1
  } cfg_e;

  typedef struct packed {
    logic              rx_valid;
    logic [BYTE_W-1:0] rx_byte;
    logic [CNT_W-1:0]  rx_index;
    logic              data_out;
    logic              data_drive;
    logic              transfer_end;
  } result_t;

endpackage

FILE: src/serial_1bit_slave_shifter.sv
// serial_1bit_slave_shifter: chip-select framed serial slave, mode 0, msb first
// an accepted result word enters the result register, or the skid stage if output is held
// throughput: one word per cycle; in_stall_o rises only when result and skid stage are full
// reset: control state clears at once; transmit ram contents stay undefined, no clearing pass
// the next transmit byte is prefetched from the ram port at tx_index + 1 with write bypass
// depends on sbs_pkg, sbs_ram and sbs_skid
module serial_1bit_slave_shifter #(
  parameter int unsigned TX_DEPTH = sbs_pkg::TX_DEPTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [sbs_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [sbs_pkg::CNT_W-1:0]       cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [1:0]                      opcode_i,
  input  logic                            cs_n_i,
  input  logic                            clk_level_i,
  input  logic                            data_in_i,
  input  logic [sbs_pkg::BYTE_W-1:0]      tx_byte_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            rx_valid_o,
  output logic [sbs_pkg::BYTE_W-1:0]      rx_byte_o,
  output logic [sbs_pkg::CNT_W-1:0]       rx_index_o,
  output logic                            data_out_o,
  output logic                            data_drive_o,
  output logic                            transfer_end_o
);

  localparam int unsigned AW    = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
  localparam int unsigned IDX_W = $clog2(TX_DEPTH + 1);
  localparam int unsigned BW    = sbs_pkg::BYTE_W;
  localparam int unsigned CW    = sbs_pkg::CNT_W;

  // configuration
  logic          drive_mode_q;
  logic [CW-1:0] rx_max_q;

  // transfer state
  logic             active_q, active_d;
  logic             last_clk_q, last_clk_d;
  logic [BW-1:0]    shift_acc_q, shift_acc_d;
  logic [2:0]       bit_count_q, bit_count_d;
  logic [CW-1:0]    rx_count_q, rx_count_d;
  logic [IDX_W-1:0] tx_len_q, tx_len_d;
  logic [IDX_W-1:0] tx_index_q, tx_index_d;
  logic [2:0]       tx_bit_q, tx_bit_d;
  logic             tx_have_q, tx_have_d;
  logic             out_level_q, out_level_d;

  // shadow copies of store[0] and store[tx_index]
  logic [BW-1:0] byte0_q, byte0_d;
  logic [BW-1:0] cur_q, cur_d;

  // ram write port and bypass of the last write
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr, raddr_q;
  logic [BW-1:0] ram_rdata, next_byte;
  logic          wr_last_en_q;
  logic [AW-1:0] wr_last_addr_q;
  logic [BW-1:0] wr_last_data_q;

  logic             accept;
  logic [IDX_W:0]   index_inc;
  logic [BW-1:0]    acc_shifted;
  sbs_pkg::result_t res;
  sbs_pkg::result_t out_res;
  logic             core_stall;

  assign accept      = in_valid_i && !core_stall;
  assign in_stall_o  = core_stall;
  assign index_inc   = {1'b0, tx_index_q} + {{IDX_W{1'b0}}, 1'b1};
  assign ram_raddr   = index_inc[AW-1:0];
  assign ram_waddr   = tx_len_q[AW-1:0];
  assign acc_shifted = {shift_acc_q[BW-2:0], data_in_i};
  assign next_byte   = (wr_last_en_q && (wr_last_addr_q == raddr_q)) ? wr_last_data_q
                                                                      : ram_rdata;

  sbs_ram #(
    .WIDTH (BW),
    .DEPTH (TX_DEPTH)
  ) u_tx_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (tx_byte_i),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    active_d    = active_q;
    last_clk_d  = last_clk_q;
    shift_acc_d = shift_acc_q;
    bit_count_d = bit_count_q;
    rx_count_d  = rx_count_q;
    tx_len_d    = tx_len_q;
    tx_index_d  = tx_index_q;
    tx_bit_d    = tx_bit_q;
    tx_have_d   = tx_have_q;
    out_level_d = out_level_q;
    byte0_d     = byte0_q;
    cur_d       = cur_q;
    ram_we      = 1'b0;
    res         = '0;

    if (accept) begin
      unique case (sbs_pkg::op_e'(opcode_i))
        sbs_pkg::OP_APPEND: begin
          if (tx_len_q < IDX_W'(TX_DEPTH)) begin
            ram_we   = 1'b1;
            tx_len_d = tx_len_q + IDX_W'(1);
            if (tx_len_q == '0) begin
              byte0_d = tx_byte_i;
            end
            if (tx_len_q == tx_index_q) begin
              cur_d = tx_byte_i;
            end
          end
        end
        sbs_pkg::OP_CLEAR: begin
          tx_len_d = '0;
        end
        sbs_pkg::OP_TICK: begin
          if (!active_q) begin
            if (!cs_n_i) begin
              active_d    = 1'b1;
              last_clk_d  = clk_level_i;
              shift_acc_d = '0;
              bit_count_d = '0;
              rx_count_d  = '0;
              tx_index_d  = '0;
              tx_bit_d    = 3'd7;
              tx_have_d   = (tx_len_q != '0);
              cur_d       = byte0_q;
              out_level_d = (tx_len_q != '0) && byte0_q[BW-1];
            end
          end else if (cs_n_i) begin
            // release: partial byte is dropped
            active_d         = 1'b0;
            res.transfer_end = 1'b1;
            shift_acc_d      = '0;
            bit_count_d      = '0;
          end else if (clk_level_i != last_clk_q) begin
            last_clk_d = clk_level_i;
            if (!drive_mode_q && clk_level_i) begin
              if (bit_count_q == 3'd7) begin
                if (rx_count_q < rx_max_q) begin
                  res.rx_valid = 1'b1;
                  res.rx_byte  = acc_shifted;
                  res.rx_index = rx_count_q;
                  rx_count_d   = rx_count_q + CW'(1);
                end
                shift_acc_d = '0;
                bit_count_d = '0;
              end else begin
                shift_acc_d = acc_shifted;
                bit_count_d = bit_count_q + 3'd1;
              end
            end else if (drive_mode_q && !clk_level_i) begin
              if (tx_have_q) begin
                if (tx_bit_q == 3'd0) begin
                  tx_index_d  = index_inc[IDX_W-1:0];
                  tx_bit_d    = 3'd7;
                  tx_have_d   = index_inc < {1'b0, tx_len_q};
                  cur_d       = next_byte;
                  out_level_d = (index_inc < {1'b0, tx_len_q}) && next_byte[BW-1];
                end else begin
                  tx_bit_d    = tx_bit_q - 3'd1;
                  out_level_d = cur_q[tx_bit_q - 3'd1];
                end
              end else begin
                out_level_d = 1'b0;
              end
            end
          end
        end
        default: begin
          // unused opcode: no state change
        end
      endcase
    end

    res.data_drive = active_d && drive_mode_q;
    res.data_out   = active_d && drive_mode_q && out_level_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drive_mode_q <= 1'b0;
      rx_max_q     <= {CW{1'b1}};
    end else if (cfg_we_i) begin
      unique case (sbs_pkg::cfg_e'(cfg_idx_i))
        sbs_pkg::CFG_DRIVE_MODE: drive_mode_q <= cfg_data_i[0];
        sbs_pkg::CFG_RX_MAX:     rx_max_q     <= cfg_data_i;
        default:                 rx_max_q     <= rx_max_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q     <= 1'b0;
      last_clk_q   <= 1'b0;
      shift_acc_q  <= '0;
      bit_count_q  <= '0;
      rx_count_q   <= '0;
      tx_len_q     <= '0;
      tx_index_q   <= '0;
      tx_bit_q     <= 3'd7;
      tx_have_q    <= 1'b0;
      out_level_q  <= 1'b0;
      wr_last_en_q <= 1'b0;
    end else begin
      active_q     <= active_d;
      last_clk_q   <= last_clk_d;
      shift_acc_q  <= shift_acc_d;
      bit_count_q  <= bit_count_d;
      rx_count_q   <= rx_count_d;
      tx_len_q     <= tx_len_d;
      tx_index_q   <= tx_index_d;
      tx_bit_q     <= tx_bit_d;
      tx_have_q    <= tx_have_d;
      out_level_q  <= out_level_d;
      wr_last_en_q <= ram_we;
    end
  end

  always_ff @(posedge clk_i) begin
    byte0_q        <= byte0_d;
    cur_q          <= cur_d;
    raddr_q        <= ram_raddr;
    wr_last_addr_q <= ram_waddr;
    wr_last_data_q <= tx_byte_i;
  end

  sbs_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (accept),
    .in_data_i   (res),
    .in_stall_o  (core_stall),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_res),
    .out_stall_i (out_stall_i)
  );

  assign rx_valid_o     = out_res.rx_valid;
  assign rx_byte_o      = out_res.rx_byte;
  assign rx_index_o     = out_res.rx_index;
  assign data_out_o     = out_res.data_out;
  assign data_drive_o   = out_res.data_drive;
  assign transfer_end_o = out_res.transfer_end;

  // stall only when a word is already waiting at the output
  a_stall_has_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no word at the output");

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tx_len_q <= IDX_W'(TX_DEPTH))
    else $error("transmit length beyond store depth");

  a_rx_not_driving: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && rx_valid_o) |-> !data_drive_o)
    else $error("received byte reported while driving");

  a_end_released: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && res.transfer_end) |=> !active_q)
    else $error("transfer end without release");

endmodule

FILE: src/sbs_ram.sv
// sbs_ram: generic single-write, single-read ram with registered read data
// read-first on a same-address write; no dependencies
module sbs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/sbs_skid.sv
// sbs_skid: result register plus skid stage between the core and the output channel
// depends on sbs_pkg for the result word type
module sbs_skid (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  sbs_pkg::result_t in_data_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  output sbs_pkg::result_t out_data_o,
  input  logic             out_stall_i
);

  logic             out_valid_q, out_valid_d;
  logic             skid_valid_q, skid_valid_d;
  sbs_pkg::result_t out_data_q, out_data_d;
  sbs_pkg::result_t skid_data_q, skid_data_d;
  logic             push, pop;

  assign in_stall_o = skid_valid_q;
  assign push       = in_valid_i && !skid_valid_q;
  assign pop        = out_valid_q && !out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    skid_valid_d = skid_valid_q;
    skid_data_d  = skid_data_q;
    if (!out_valid_q || pop) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = push;
        if (push) begin
          out_data_d = in_data_i;
        end
      end
    end else if (push) begin
      // output held, park the new word
      skid_valid_d = 1'b1;
      skid_data_d  = in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
